FILE: rtl/clock_frame_replacement_assert.svh
// Assertion macros used by the clock frame replacement RTL.
`ifndef CLOCK_FRAME_REPLACEMENT_ASSERT_SVH
`define CLOCK_FRAME_REPLACEMENT_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked at every rising edge, disabled while reset is high.
`define CFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every rising edge, reset included.
`define CFR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFR_ASSERT(label, clk, rst, prop, msg)
`define CFR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/cfr_pkg.sv
// Types, sizes and codes shared by the clock frame replacement block.
`default_nettype none
package cfr_pkg;
   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int FRAME_W = 20;
   localparam int PAGE_W  = 20;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_TOUCH = 3'd2;
   localparam logic [2:0] OP_PIN   = 3'd3;
   localparam logic [2:0] OP_EVICT = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NO_VICTIM = 2'd3;

   localparam logic [1:0] WB_NONE = 2'd0;
   localparam logic [1:0] WB_FILE = 2'd1;
   localparam logic [1:0] WB_SWAP = 2'd2;

   typedef struct packed {
      logic mmap;
      logic dirty;
      logic accessed;
      logic pinned;
   } mark_type;

   typedef struct packed {
      mark_type            mark;
      logic [PAGE_W-1:0]   page;
      logic [FRAME_W-1:0]  frame;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_RD   = 7'b0000100,
      S_CHK  = 7'b0001000,
      S_MVRD = 7'b0010000,
      S_MVWR = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/clock_frame_replacement.sv
// Clock (second-chance) frame table: top level with its scan sequencer.
//
// One request channel (req_*) carries add, free, touch, set pin and evict
// transactions; one response channel (rsp_*) returns exactly one result per
// request, in order. Both use valid/ready.
// The table lives in one RAM with a registered read, so every entry the
// sequencer inspects passes through a read state and then a check state.
// Add writes the new entry at the end of the table. Free, touch and set
// pin scan from the head until the frame is found or the last entry is
// checked; free then closes the gap by moving each later entry down one
// place. Evict scans from the head for up to two passes and closes the gap
// behind the victim.
// A new request is taken only while the sequencer is idle, in the cycle
// after the previous result is loaded; a finished result waits in the output
// register while the next request is taken, and a stalled receiver holds
// the sequencer in its done state.
// Reset empties the table at once (the entry count goes to zero); the
// RAM contents are not cleared and entries at or above the count are never used.
`default_nettype none
`include "clock_frame_replacement_assert.svh"
module clock_frame_replacement (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [19:0] req_frame_number,
   input  wire logic [19:0] req_page_number,
   input  wire logic        req_is_mmap,
   input  wire logic        req_is_write,
   input  wire logic        req_pin_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [19:0]      rsp_victim_frame,
   output logic [19:0]      rsp_victim_page,
   output logic [1:0]       rsp_writeback_action
);
   localparam int IDX_W = cfr_pkg::IDX_W;
   localparam int CNT_W = cfr_pkg::CNT_W;

   cfr_pkg::state_type state_ff, state_in;

   logic [2:0]  op_ff, op_in;
   logic [19:0] frame_ff, frame_in;
   logic [19:0] page_ff, page_in;
   logic        mmap_ff, mmap_in;
   logic        write_ff, write_in;
   logic        pinv_ff, pinv_in;

   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             pass_ff, pass_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [19:0] res_frame_ff, res_frame_in;
   logic [19:0] res_page_ff, res_page_in;
   logic [1:0]  res_act_ff, res_act_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [19:0] rsp_frame_ff, rsp_frame_in;
   logic [19:0] rsp_page_ff, rsp_page_in;
   logic [1:0]  rsp_act_ff, rsp_act_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   cfr_pkg::entry_type   ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   cfr_pkg::entry_type   ram_rdata;

   logic [CNT_W-1:0] ptr_next;
   logic             ptr_last;
   logic             req_fire;

   cfr_ram #(
      .WIDTH (cfr_pkg::ENTRY_W),
      .DEPTH (cfr_pkg::ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == cfr_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign ptr_next  = CNT_W'(ptr_ff) + CNT_W'(1);
   assign ptr_last  = (ptr_next == cnt_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      frame_in      = frame_ff;
      page_in       = page_ff;
      mmap_in       = mmap_ff;
      write_in      = write_ff;
      pinv_in       = pinv_ff;
      ptr_in        = ptr_ff;
      pass_in       = pass_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_page_in   = res_page_ff;
      res_act_in    = res_act_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_act_in    = rsp_act_ff;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = ptr_ff;

      unique case (state_ff)
         cfr_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in    = req_op;
               frame_in = req_frame_number;
               page_in  = req_page_number;
               mmap_in  = req_is_mmap;
               write_in = req_is_write;
               pinv_in  = req_pin_value;
               state_in = cfr_pkg::S_EXEC;
            end
         end
         cfr_pkg::S_EXEC: begin
            res_status_in = cfr_pkg::ST_OK;
            res_frame_in  = '0;
            res_page_in   = '0;
            res_act_in    = cfr_pkg::WB_NONE;
            ptr_in        = '0;
            pass_in       = 1'b0;
            state_in      = cfr_pkg::S_DONE;
            if (op_ff == cfr_pkg::OP_ADD) begin
               if (cnt_ff >= CNT_W'(cfr_pkg::ENTRIES)) begin
                  res_status_in = cfr_pkg::ST_FULL;
               end else begin
                  ram_we                   = 1'b1;
                  ram_waddr                = IDX_W'(cnt_ff);
                  ram_wdata.frame          = frame_ff;
                  ram_wdata.page           = page_ff;
                  ram_wdata.mark           = '0;
                  ram_wdata.mark.mmap      = mmap_ff;
                  cnt_in                   = cnt_ff + CNT_W'(1);
               end
            end else if (op_ff == cfr_pkg::OP_FREE || op_ff == cfr_pkg::OP_TOUCH ||
                         op_ff == cfr_pkg::OP_PIN) begin
               if (cnt_ff == '0) begin
                  res_status_in = cfr_pkg::ST_NOT_FOUND;
               end else begin
                  state_in = cfr_pkg::S_RD;
               end
            end else if (op_ff == cfr_pkg::OP_EVICT) begin
               if (cnt_ff == '0) begin
                  res_status_in = cfr_pkg::ST_NO_VICTIM;
               end else begin
                  state_in = cfr_pkg::S_RD;
               end
            end
         end
         cfr_pkg::S_RD: begin
            ram_raddr = ptr_ff;
            state_in  = cfr_pkg::S_CHK;
         end
         cfr_pkg::S_CHK: begin
            state_in = cfr_pkg::S_RD;
            if (op_ff == cfr_pkg::OP_EVICT) begin
               if (!ram_rdata.mark.pinned && !ram_rdata.mark.accessed) begin
                  res_frame_in = ram_rdata.frame;
                  res_page_in  = ram_rdata.page;
                  if (ram_rdata.mark.dirty) begin
                     res_act_in = ram_rdata.mark.mmap ? cfr_pkg::WB_FILE : cfr_pkg::WB_SWAP;
                  end
                  state_in = cfr_pkg::S_MVRD;
               end else begin
                  // Second chance: an unpinned entry loses its accessed mark.
                  if (!ram_rdata.mark.pinned) begin
                     ram_we                  = 1'b1;
                     ram_wdata.mark.accessed = 1'b0;
                  end
                  if (ptr_last) begin
                     if (pass_ff) begin
                        res_status_in = cfr_pkg::ST_NO_VICTIM;
                        state_in      = cfr_pkg::S_DONE;
                     end else begin
                        ptr_in  = '0;
                        pass_in = 1'b1;
                     end
                  end else begin
                     ptr_in = IDX_W'(ptr_next);
                  end
               end
            end else if (ram_rdata.frame == frame_ff) begin
               if (op_ff == cfr_pkg::OP_FREE) begin
                  state_in = cfr_pkg::S_MVRD;
               end else begin
                  ram_we = 1'b1;
                  if (op_ff == cfr_pkg::OP_TOUCH) begin
                     ram_wdata.mark.accessed = 1'b1;
                     ram_wdata.mark.dirty    = ram_rdata.mark.dirty | write_ff;
                  end else begin
                     ram_wdata.mark.pinned = pinv_ff;
                  end
                  state_in = cfr_pkg::S_DONE;
               end
            end else if (ptr_last) begin
               res_status_in = cfr_pkg::ST_NOT_FOUND;
               state_in      = cfr_pkg::S_DONE;
            end else begin
               ptr_in = IDX_W'(ptr_next);
            end
         end
         cfr_pkg::S_MVRD: begin
            // Close the gap: entry ptr+1 moves down to ptr.
            if (ptr_next >= cnt_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = cfr_pkg::S_DONE;
            end else begin
               ram_raddr = IDX_W'(ptr_next);
               state_in  = cfr_pkg::S_MVWR;
            end
         end
         cfr_pkg::S_MVWR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = ram_rdata;
            ptr_in    = IDX_W'(ptr_next);
            state_in  = cfr_pkg::S_MVRD;
         end
         cfr_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_frame_in  = res_frame_ff;
               rsp_page_in   = res_page_ff;
               rsp_act_in    = res_act_ff;
               state_in      = cfr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfr_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      frame_ff      <= frame_in;
      page_ff       <= page_in;
      mmap_ff       <= mmap_in;
      write_ff      <= write_in;
      pinv_ff       <= pinv_in;
      ptr_ff        <= ptr_in;
      pass_ff       <= pass_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_page_ff   <= res_page_in;
      res_act_ff    <= res_act_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_act_ff    <= rsp_act_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_victim_frame     = rsp_frame_ff;
   assign rsp_victim_page      = rsp_page_ff;
   assign rsp_writeback_action = rsp_act_ff;

   // An accepted transaction always starts execution on the next cycle.
   `CFR_ASSERT(a_fire_starts, clock, reset, req_fire |=> (state_ff == cfr_pkg::S_EXEC), "request not started")
   // The scan pointer stays inside the resident part of the table while checking.
   `CFR_ASSERT(a_chk_in_range, clock, reset, (state_ff == cfr_pkg::S_CHK) |-> (CNT_W'(ptr_ff) < cnt_ff), "scan pointer past entry count")
   // Finishing a gap close removes exactly one entry.
   `CFR_ASSERT(a_remove_one, clock, reset, ((state_ff == cfr_pkg::S_MVRD) && (ptr_next >= cnt_ff)) |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)), "removal did not drop count by one")
   // The entry count never exceeds the table size.
   `CFR_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(cfr_pkg::ENTRIES), "entry count overflow")
endmodule
`default_nettype wire

FILE: rtl/cfr_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                   wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                   rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: tb/sv/clock_frame_replacement_tb.sv
// Self-checking testbench for the clock frame replacement table.
`timescale 1ns / 100ps
module clock_frame_replacement_tb;
   localparam int FRAME_W = cfr_pkg::FRAME_W;
   localparam int PAGE_W = cfr_pkg::PAGE_W;
   localparam int ENTRIES = cfr_pkg::ENTRIES;
   localparam logic [2:0] OP_LAST = 3'd7;
   localparam int RANDOM_ITEMS = 1030;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [2:0]         op;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  page;
      logic               mmap;
      logic               write;
      logic               pin;
      logic               hold_until_idle;
   } frame_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FRAME_W-1:0] vframe;
      logic [PAGE_W-1:0]  vpage;
      logic [1:0]         action;
   } frame_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_op = cfr_pkg::OP_ADD;
   logic [19:0]        req_frame_number = '0;
   logic [19:0]        req_page_number = '0;
   logic               req_is_mmap = 1'b0;
   logic               req_is_write = 1'b0;
   logic               req_pin_value = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [19:0]        rsp_victim_frame;
   logic [19:0]        rsp_victim_page;
   logic [1:0]         rsp_writeback_action;

   clock_frame_replacement u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_frame_number     (req_frame_number),
      .req_page_number      (req_page_number),
      .req_is_mmap          (req_is_mmap),
      .req_is_write         (req_is_write),
      .req_pin_value        (req_pin_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_victim_frame     (rsp_victim_frame),
      .rsp_victim_page      (rsp_victim_page),
      .rsp_writeback_action (rsp_writeback_action)
   );

   // Shadow copy of the frame table.
   logic [FRAME_W-1:0]  tbl_frame [ENTRIES];
   logic [PAGE_W-1:0]   tbl_page [ENTRIES];
   cfr_pkg::mark_type   tbl_mark [ENTRIES];
   int                  tbl_count = 0;

   frame_req_type pending_reqs[$];
   frame_rsp_type expected_rsps[$];
   frame_req_type cur_req;
   logic [FRAME_W-1:0] frame_pool [16];
   int send_gap = 0;
   int send_calm = 0;
   int recv_stall = 0;
   int recv_calm = 0;
   int mismatches = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int find_entry(input logic [FRAME_W-1:0] f);
      int i;
      for (i = 0; i < tbl_count; i++) begin
         if (tbl_frame[i] == f) return i;
      end
      return tbl_count;
   endfunction

   function automatic void drop_entry(input int idx);
      int i;
      for (i = idx; i + 1 < tbl_count; i++) begin
         tbl_frame[i] = tbl_frame[i + 1];
         tbl_page[i]  = tbl_page[i + 1];
         tbl_mark[i]  = tbl_mark[i + 1];
      end
      tbl_count--;
   endfunction

   // Applies one transaction to the shadow table and returns its result.
   function automatic frame_rsp_type table_step(input frame_req_type r);
      frame_rsp_type res;
      int idx;
      int i;
      int k;
      bit any_unpinned;
      bit found;
      res = '0;
      case (r.op)
         cfr_pkg::OP_ADD: begin
            if (tbl_count >= ENTRIES) begin
               res.status = cfr_pkg::ST_FULL;
            end else begin
               tbl_frame[tbl_count] = r.frame;
               tbl_page[tbl_count] = r.page;
               tbl_mark[tbl_count] = '0;
               tbl_mark[tbl_count].mmap = r.mmap;
               tbl_count++;
            end
         end
         cfr_pkg::OP_FREE: begin
            idx = find_entry(r.frame);
            if (idx >= tbl_count) res.status = cfr_pkg::ST_NOT_FOUND;
            else drop_entry(idx);
         end
         cfr_pkg::OP_TOUCH: begin
            idx = find_entry(r.frame);
            if (idx >= tbl_count) begin
               res.status = cfr_pkg::ST_NOT_FOUND;
            end else begin
               tbl_mark[idx].accessed = 1'b1;
               if (r.write) tbl_mark[idx].dirty = 1'b1;
            end
         end
         cfr_pkg::OP_PIN: begin
            idx = find_entry(r.frame);
            if (idx >= tbl_count) res.status = cfr_pkg::ST_NOT_FOUND;
            else tbl_mark[idx].pinned = r.pin;
         end
         cfr_pkg::OP_EVICT: begin
            any_unpinned = 1'b0;
            for (i = 0; i < tbl_count; i++) begin
               if (!tbl_mark[i].pinned) any_unpinned = 1'b1;
            end
            if (!any_unpinned) begin
               res.status = cfr_pkg::ST_NO_VICTIM;
            end else begin
               // Second chance: an unpinned accessed entry loses its mark and is passed over.
               found = 1'b0;
               idx = 0;
               for (i = 0; i < 2 * tbl_count && !found; i++) begin
                  k = i % tbl_count;
                  if (!tbl_mark[k].pinned) begin
                     if (tbl_mark[k].accessed) begin
                        tbl_mark[k].accessed = 1'b0;
                     end else begin
                        idx = k;
                        found = 1'b1;
                     end
                  end
               end
               if (!found) begin
                  res.status = cfr_pkg::ST_NO_VICTIM;
               end else begin
                  res.vframe = tbl_frame[idx];
                  res.vpage = tbl_page[idx];
                  if (tbl_mark[idx].dirty) begin
                     res.action = tbl_mark[idx].mmap ? cfr_pkg::WB_FILE : cfr_pkg::WB_SWAP;
                  end else begin
                     res.action = cfr_pkg::WB_NONE;
                  end
                  drop_entry(idx);
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a stretch with none.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_req(input logic [2:0] op, input logic [FRAME_W-1:0] f,
                                     input logic [PAGE_W-1:0] p, input logic mm,
                                     input logic wr, input logic pv, input logic hold);
      frame_req_type r;
      r.op = op;
      r.frame = f;
      r.page = p;
      r.mmap = mm;
      r.write = wr;
      r.pin = pv;
      r.hold_until_idle = hold;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [FRAME_W-1:0] random_frame();
      if ($urandom_range(0, 99) < 85) return frame_pool[$urandom_range(0, 15)];
      return FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1));
   endfunction

   function automatic logic [PAGE_W-1:0] random_page();
      return PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
   endfunction

   function automatic logic random_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Driver: presents queued requests and updates the shadow table on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(table_step(cur_req));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].hold_until_idle && expected_rsps.size() != 0)) begin
               cur_req = pending_reqs.pop_front();
               req_op <= cur_req.op;
               req_frame_number <= cur_req.frame;
               req_page_number <= cur_req.page;
               req_is_mmap <= cur_req.mmap;
               req_is_write <= cur_req.write;
               req_pin_value <= cur_req.pin;
               req_valid <= 1'b1;
               send_gap = pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response against the oldest prediction.
   always @(posedge clock) begin
      frame_rsp_type got;
      frame_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.vframe = rsp_victim_frame;
            got.vpage = rsp_victim_page;
            got.action = rsp_writeback_action;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("Unexpected response: status %0d frame %h page %h action %0d",
                           got.status, got.vframe, got.vpage, got.action);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status || got.vframe !== want.vframe ||
                   got.vpage !== want.vpage || got.action !== want.action) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("Mismatch: expected status %0d frame %h page %h action %0d, %s",
                              want.status, want.vframe, want.vpage, want.action,
                              $sformatf("got status %0d frame %h page %h action %0d",
                                        got.status, got.vframe, got.vpage, got.action));
               end
            end
            recv_stall = pick_gap(recv_calm);
         end else if (!rsp_valid && recv_stall == 0 && $urandom_range(0, 49) == 0) begin
            recv_stall = pick_gap(recv_calm);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int generated;
      int phase_len;
      int kind;
      int r;
      int i;
      logic [2:0] op;
      logic pv;
      logic hold;

      for (i = 0; i < 16; i++) frame_pool[i] = random_page();
      frame_pool[0] = '0;
      frame_pool[1] = '1;

      // Directed part.
      queue_req(cfr_pkg::OP_EVICT, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);   // empty table: no victim
      queue_req(cfr_pkg::OP_FREE, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_TOUCH, '1, '1, 1'b1, 1'b1, 1'b1, 1'b0);
      queue_req(cfr_pkg::OP_PIN, '1, '0, 1'b0, 1'b0, 1'b1, 1'b0);
      queue_req(cfr_pkg::OP_ADD, '0, '1, 1'b1, 1'b1, 1'b1, 1'b0);
      queue_req(cfr_pkg::OP_ADD, '1, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_ADD, '0, 20'h12345, 1'b0, 1'b0, 1'b0, 1'b0);   // duplicate frame
      queue_req(cfr_pkg::OP_TOUCH, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_TOUCH, '1, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_PIN, '1, '0, 1'b0, 1'b0, 1'b1, 1'b0);
      queue_req(cfr_pkg::OP_PIN, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
      queue_req(cfr_pkg::OP_EVICT, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);   // takes the clean duplicate
      queue_req(cfr_pkg::OP_EVICT, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);   // all pinned now
      queue_req(cfr_pkg::OP_PIN, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_EVICT, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);   // wraps, dirty mmap page
      queue_req(cfr_pkg::OP_PIN, '1, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_TOUCH, '1, '0, 1'b0, 1'b1, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_EVICT, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);   // dirty anonymous page
      for (op = cfr_pkg::OP_EVICT + 3'd1; op != cfr_pkg::OP_ADD; op++)
         queue_req(op, random_frame(), random_page(), random_bit(), random_bit(),
                   random_bit(), 1'b0);
      queue_req(cfr_pkg::OP_FREE, 20'hABCDE, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_ADD, 20'h5A5A5, 20'hA5A5A, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_req(cfr_pkg::OP_FREE, 20'h5A5A5, '0, 1'b0, 1'b0, 1'b0, 1'b0);

      // Random part, in phases that fill, drain, mix or pin heavily.
      generated = 0;
      hold = 1'b1;
      while (generated < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 3);
         phase_len = $urandom_range(40, 120);
         for (i = 0; i < phase_len && generated < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            case (kind)
               0: op = (r < 70) ? cfr_pkg::OP_ADD : (r < 75) ? cfr_pkg::OP_FREE :
                       (r < 87) ? cfr_pkg::OP_TOUCH : (r < 92) ? cfr_pkg::OP_PIN :
                       (r < 97) ? cfr_pkg::OP_EVICT : OP_LAST;
               1: op = (r < 10) ? cfr_pkg::OP_ADD : (r < 30) ? cfr_pkg::OP_FREE :
                       (r < 45) ? cfr_pkg::OP_TOUCH : (r < 52) ? cfr_pkg::OP_PIN :
                       (r < 97) ? cfr_pkg::OP_EVICT : OP_LAST;
               2: op = (r < 30) ? cfr_pkg::OP_ADD : (r < 40) ? cfr_pkg::OP_FREE :
                       (r < 65) ? cfr_pkg::OP_TOUCH : (r < 77) ? cfr_pkg::OP_PIN :
                       (r < 97) ? cfr_pkg::OP_EVICT : OP_LAST;
               default: op = (r < 25) ? cfr_pkg::OP_ADD : (r < 30) ? cfr_pkg::OP_FREE :
                             (r < 50) ? cfr_pkg::OP_TOUCH : (r < 80) ? cfr_pkg::OP_PIN :
                             (r < 97) ? cfr_pkg::OP_EVICT : OP_LAST;
            endcase
            if (op == OP_LAST) op = 3'($urandom_range(cfr_pkg::OP_EVICT + 1, OP_LAST));
            if (kind == 3) pv = ($urandom_range(0, 99) < 85);
            else pv = random_bit();
            queue_req(op, random_frame(), random_page(), random_bit(), random_bit(),
                      pv, hold);
            hold = 1'b0;
            generated++;
         end
         // Now and then let the block drain completely before the next phase.
         hold = ($urandom_range(0, 3) == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
